// ===== rtl/core/sgsw_pkg.sv =====
// shared types, register codes and the row expansion function of the glyph span writer
`timescale 1ns / 1ps

package sgsw_pkg;

   localparam int GLYPH_SIZE      = 8;
   localparam int SCALE_LIMIT     = 8;
   localparam int MAX_SCALE_DEF   = 8;
   localparam int MAX_DIM_DEF     = 4096;

   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ROW_STRIDE    = 2'd2;

   localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
   localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;
   localparam logic [13:0] ROW_STRIDE_RST    = 14'd640;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [13:0] row_stride;
   } csr_type;

   typedef struct packed {
      logic        valid;
      logic        flush;
      logic [7:0]  row_byte;
      logic [3:0]  scale;
      logic [16:0] y;
      logic [15:0] x;
      logic [31:0] color;
      logic [63:0] clip;
   } seq_tok_type;

   typedef struct packed {
      logic        valid;
      logic        flush;
      logic        emit;
      logic [63:0] mask;
      logic [24:0] prod;
      logic [15:0] x;
      logic [31:0] color;
   } row_tok_type;

   function automatic logic [63:0] expand_row(logic [7:0] row_byte, logic [3:0] scale);
      logic [63:0] m;
      m = '0;
      for (int sc = 1; sc <= SCALE_LIMIT; sc++) begin
         if (scale == 4'(sc)) begin
            for (int c = 0; c < GLYPH_SIZE; c++) begin
               for (int k = 0; k < sc; k++) begin
                  m[c * sc + k] = row_byte[GLYPH_SIZE - 1 - c];
               end
            end
         end
      end
      return m;
   endfunction

endpackage

// ===== rtl/core/sgsw_csr.sv =====
// configuration registers: width, height and stride
`timescale 1ns / 1ps

module sgsw_csr
   import sgsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output csr_type     csr_out
);

   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [13:0] stride_ff, stride_in;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SCREEN_WIDTH:  width_in  = csr_wdata[12:0];
            REG_SCREEN_HEIGHT: height_in = csr_wdata[12:0];
            REG_ROW_STRIDE:    stride_in = csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RST;
         height_ff <= SCREEN_HEIGHT_RST;
         stride_ff <= ROW_STRIDE_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
      end
   end

   assign csr_out.screen_width  = width_ff;
   assign csr_out.screen_height = height_ff;
   assign csr_out.row_stride    = stride_ff;

endmodule

// ===== rtl/core/sgsw_seq.sv =====
// glyph capture, right clip mask and row sequencer
`timescale 1ns / 1ps

module sgsw_seq
   import sgsw_pkg::*;
#(
   parameter int MAX_SCALE = MAX_SCALE_DEF,
   parameter int MAX_DIM   = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_glyph_bits,
   input  logic [15:0] req_left_x,
   input  logic [15:0] req_top_y,
   input  logic [3:0]  req_scale_factor,
   input  logic [31:0] req_pixel_color,
   input  csr_type     csr,
   input  logic        advance,
   output seq_tok_type tok
);

   localparam int SW = $clog2(MAX_SCALE + 1);

   logic              busy_ff, busy_in;
   logic              flush_ff, flush_in;
   logic [63:0]       glyph_ff, glyph_in;
   logic [15:0]       x_ff, x_in;
   logic [16:0]       y_ff, y_in;
   logic [3:0]        scale_ff, scale_in;
   logic [31:0]       color_ff, color_in;
   logic [63:0]       clip_ff, clip_in;
   logic [2:0]        r_ff, r_in;
   logic [SW-1:0]     s_ff, s_in;
   seq_tok_type       tok_ff, tok_in;

   logic              accept;
   logic [13:0]       w_sat;
   logic [16:0]       w_diff;
   logic [63:0]       clip_new;
   logic              s_end;

   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;

   always_comb begin
      w_sat  = (14'(csr.screen_width) > 14'(MAX_DIM)) ? 14'(MAX_DIM) : 14'(csr.screen_width);
      w_diff = 17'(w_sat) - 17'(req_left_x);
      if (req_left_x >= 16'(w_sat)) begin
         clip_new = '0;
      end else if (w_diff >= 17'd64) begin
         clip_new = '1;
      end else begin
         clip_new = (64'd1 << w_diff[5:0]) - 64'd1;
      end
   end

   assign s_end = (4'(s_ff) + 4'd1) == scale_ff;

   always_comb begin
      busy_in  = busy_ff;
      flush_in = flush_ff;
      glyph_in = glyph_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      scale_in = scale_ff;
      color_in = color_ff;
      clip_in  = clip_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      tok_in   = tok_ff;

      if (accept) begin
         busy_in  = 1'b1;
         flush_in = 1'b0;
         glyph_in = req_glyph_bits;
         x_in     = req_left_x;
         y_in     = 17'(req_top_y);
         scale_in = (req_scale_factor > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : req_scale_factor;
         color_in = req_pixel_color;
         clip_in  = clip_new;
         r_in     = '0;
         s_in     = '0;
      end

      if (advance) begin
         tok_in.valid    = busy_ff;
         tok_in.flush    = flush_ff || (scale_ff == 4'd0);
         tok_in.row_byte = glyph_ff[8 * r_ff +: 8];
         tok_in.scale    = scale_ff;
         tok_in.y        = y_ff;
         tok_in.x        = x_ff;
         tok_in.color    = color_ff;
         tok_in.clip     = clip_ff;
         if (busy_ff) begin
            if (flush_ff || scale_ff == 4'd0) begin
               busy_in = 1'b0;
            end else begin
               y_in = y_ff + 17'd1;
               if (s_end) begin
                  s_in = '0;
                  r_in = r_ff + 3'd1;
                  if (r_ff == 3'(GLYPH_SIZE - 1)) begin
                     flush_in = 1'b1;
                  end
               end else begin
                  s_in = s_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         tok_ff.valid <= tok_in.valid;
      end
      flush_ff          <= flush_in;
      glyph_ff          <= glyph_in;
      x_ff              <= x_in;
      y_ff              <= y_in;
      scale_ff          <= scale_in;
      color_ff          <= color_in;
      clip_ff           <= clip_in;
      r_ff              <= r_in;
      s_ff              <= s_in;
      tok_ff.flush      <= tok_in.flush;
      tok_ff.row_byte   <= tok_in.row_byte;
      tok_ff.scale      <= tok_in.scale;
      tok_ff.y          <= tok_in.y;
      tok_ff.x          <= tok_in.x;
      tok_ff.color      <= tok_in.color;
      tok_ff.clip       <= tok_in.clip;
   end

   assign tok = tok_ff;

endmodule

// ===== rtl/core/sgsw_row.sv =====
// row stage: magnified mask, bottom clip and row offset product
`timescale 1ns / 1ps

module sgsw_row
   import sgsw_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  csr_type     csr,
   input  logic        advance,
   input  seq_tok_type tok,
   output row_tok_type row
);

   row_tok_type row_ff, row_in;
   logic [13:0] h_sat;
   logic [63:0] mask;
   logic [30:0] prod;

   always_comb begin
      h_sat = (14'(csr.screen_height) > 14'(MAX_DIM)) ? 14'(MAX_DIM) : 14'(csr.screen_height);
      mask  = expand_row(tok.row_byte, tok.scale) & tok.clip;
      prod  = 31'(tok.y) * 31'(csr.row_stride);
      row_in = row_ff;
      if (advance) begin
         row_in.valid = tok.valid;
         row_in.flush = tok.flush;
         row_in.emit  = tok.valid && !tok.flush && (tok.y < 17'(h_sat)) && (mask != '0);
         row_in.mask  = mask;
         row_in.prod  = prod[24:0];
         row_in.x     = tok.x;
         row_in.color = tok.color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff.valid <= 1'b0;
         row_ff.flush <= 1'b0;
         row_ff.emit  <= 1'b0;
      end else begin
         row_ff.valid <= row_in.valid;
         row_ff.flush <= row_in.flush;
         row_ff.emit  <= row_in.emit;
      end
      row_ff.mask  <= row_in.mask;
      row_ff.prod  <= row_in.prod;
      row_ff.x     <= row_in.x;
      row_ff.color <= row_in.color;
   end

   assign row = row_ff;

endmodule

// ===== rtl/core/sgsw_emit.sv =====
// one-row hold for the last flag, address add and result register
`timescale 1ns / 1ps

module sgsw_emit
   import sgsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  row_tok_type row,
   output logic        advance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [24:0] rsp_row_address,
   output logic [63:0] rsp_pixel_mask,
   output logic [31:0] rsp_write_color,
   output logic        rsp_last_row
);

   logic        pend_valid_ff, pend_valid_in;
   logic [24:0] pend_prod_ff, pend_prod_in;
   logic [15:0] pend_x_ff, pend_x_in;
   logic [63:0] pend_mask_ff, pend_mask_in;
   logic [31:0] pend_color_ff, pend_color_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [24:0] rsp_addr_ff, rsp_addr_in;
   logic [63:0] rsp_mask_ff, rsp_mask_in;
   logic [31:0] rsp_color_ff, rsp_color_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        release_row;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign release_row = row.valid && (row.emit || row.flush) && pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_prod_in  = pend_prod_ff;
      pend_x_in     = pend_x_ff;
      pend_mask_in  = pend_mask_ff;
      pend_color_in = pend_color_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = release_row;
         if (release_row) begin
            rsp_addr_in  = pend_prod_ff + {9'd0, pend_x_ff};
            rsp_mask_in  = pend_mask_ff;
            rsp_color_in = pend_color_ff;
            rsp_last_in  = row.flush;
         end
         if (row.valid && row.emit) begin
            pend_valid_in = 1'b1;
            pend_prod_in  = row.prod;
            pend_x_in     = row.x;
            pend_mask_in  = row.mask;
            pend_color_in = row.color;
         end else if (row.valid && row.flush) begin
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_prod_ff  <= pend_prod_in;
      pend_x_ff     <= pend_x_in;
      pend_mask_ff  <= pend_mask_in;
      pend_color_ff <= pend_color_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_address = rsp_addr_ff;
   assign rsp_pixel_mask  = rsp_mask_ff;
   assign rsp_write_color = rsp_color_ff;
   assign rsp_last_row    = rsp_last_ff;

`ifndef SYNTHESIS
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (advance && row.valid && row.flush && !pend_valid_ff) |=> !rsp_valid_ff)
      else $error("flush with empty hold produced a beat");
   a_emit_held: assert property (@(posedge clock) disable iff (reset)
      (advance && row.valid && row.emit) |=> pend_valid_ff)
      else $error("emitted row not captured in hold");
   a_not_last_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> pend_valid_ff)
      else $error("non-final row shown with nothing held behind it");
`endif

endmodule

// ===== rtl/core/scaled_glyph_span_writer.sv =====
// path: the sequencer captures the glyph beat; each row then passes the token register, the row
// register, the one-row hold and the result register, one row per cycle while rsp_stall is low;
// a new glyph is taken only once the sequencer is idle: it walks every magnified row, a flush
// slot, then frees a one-row hold before the result register sets the last-row flag
// reset: synchronous, clears all valid and busy state; registers return to 640, 480, 640
`timescale 1ns / 1ps

module scaled_glyph_span_writer
   import sgsw_pkg::*;
#(
   parameter int MAX_SCALE = MAX_SCALE_DEF,
   parameter int MAX_DIM   = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_glyph_bits,
   input  logic [15:0] req_left_x,
   input  logic [15:0] req_top_y,
   input  logic [3:0]  req_scale_factor,
   input  logic [31:0] req_pixel_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [24:0] rsp_row_address,
   output logic [63:0] rsp_pixel_mask,
   output logic [31:0] rsp_write_color,
   output logic        rsp_last_row,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   csr_type     csr;
   logic        advance;
   seq_tok_type tok;
   row_tok_type row;

   sgsw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_out   (csr)
   );

   sgsw_seq #(
      .MAX_SCALE (MAX_SCALE),
      .MAX_DIM   (MAX_DIM)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_glyph_bits   (req_glyph_bits),
      .req_left_x       (req_left_x),
      .req_top_y        (req_top_y),
      .req_scale_factor (req_scale_factor),
      .req_pixel_color  (req_pixel_color),
      .csr              (csr),
      .advance          (advance),
      .tok              (tok)
   );

   sgsw_row #(
      .MAX_DIM (MAX_DIM)
   ) u_row (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .advance (advance),
      .tok     (tok),
      .row     (row)
   );

   sgsw_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .row             (row),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_address (rsp_row_address),
      .rsp_pixel_mask  (rsp_pixel_mask),
      .rsp_write_color (rsp_write_color),
      .rsp_last_row    (rsp_last_row)
   );

endmodule
